### rtl/coc_pkg.sv
`default_nettype none

package coc_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int LENGTH_BITS       = 32;
    localparam int ANGLE_BITS        = 16;

    // port width of every coordinate field and result
    localparam int OW    = 32;
    // length width actually used
    localparam int LW    = (LENGTH_BITS < OW) ? LENGTH_BITS : OW;
    // CORDIC x/y in Q2.30, angle in 2^-32 turn units
    localparam int CW    = 32;
    localparam int ZW    = 32;
    localparam int TURN_W = 32;
    localparam int FRAC  = 30;
    // first product, rounded length, second product
    localparam int PW    = LW + CW;
    localparam int RW    = LW + 2;
    localparam int QW    = RW + CW;
    localparam int SHW   = $clog2(CORDIC_ITERATIONS);

    localparam int POST_LAT = 5;
    localparam int LATENCY  = 1 + CORDIC_ITERATIONS + POST_LAT;

    localparam int ATAN_ENTRIES = 30;
    localparam logic signed [ZW-1:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    localparam longint GAIN_BASE_Q30 = 64'sd652032874;
    localparam longint GAIN_TAIL     = 64'sd434688583;
    localparam longint GAIN_Q30      = GAIN_BASE_Q30 + (GAIN_TAIL >>> (2 * CORDIC_ITERATIONS));
    localparam longint ROUND_HALF    = 64'sd1 <<< (FRAC - 1);

    localparam logic [1:0] CMD_CART = 2'd0;
    localparam logic [1:0] CMD_CYL  = 2'd1;
    localparam logic [1:0] CMD_SPH  = 2'd2;

    typedef struct packed {
        logic [1:0]             cmd;
        logic signed [LW-1:0]   a;
        logic signed [LW-1:0]   len2;
        logic signed [LW-1:0]   len3;
        logic [1:0]             qa;
        logic [1:0]             qb;
        logic signed [CW-1:0]   xa;
        logic signed [CW-1:0]   ya;
        logic signed [ZW-1:0]   za;
        logic signed [CW-1:0]   xb;
        logic signed [CW-1:0]   yb;
        logic signed [ZW-1:0]   zb;
    } t_beat;

endpackage

`default_nettype wire

### rtl/coc_cell.sv
`default_nettype none

module coc_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [coc_pkg::SHW-1:0]       i_shift,
    input  wire logic signed [coc_pkg::ZW-1:0] i_atan,
    input  wire logic                          i_valid,
    input  wire coc_pkg::t_beat                i_beat,
    output logic                               o_valid,
    output coc_pkg::t_beat                     o_beat
);
    import coc_pkg::*;

    t_beat n_beat;
    t_beat r_beat;
    logic  r_valid;

    // one micro-rotation on each of the two angle paths
    always_comb begin
        n_beat = i_beat;
        if (i_beat.za >= 0) begin
            n_beat.xa = i_beat.xa - (i_beat.ya >>> i_shift);
            n_beat.ya = i_beat.ya + (i_beat.xa >>> i_shift);
            n_beat.za = i_beat.za - i_atan;
        end else begin
            n_beat.xa = i_beat.xa + (i_beat.ya >>> i_shift);
            n_beat.ya = i_beat.ya - (i_beat.xa >>> i_shift);
            n_beat.za = i_beat.za + i_atan;
        end
        if (i_beat.zb >= 0) begin
            n_beat.xb = i_beat.xb - (i_beat.yb >>> i_shift);
            n_beat.yb = i_beat.yb + (i_beat.xb >>> i_shift);
            n_beat.zb = i_beat.zb - i_atan;
        end else begin
            n_beat.xb = i_beat.xb + (i_beat.yb >>> i_shift);
            n_beat.yb = i_beat.yb - (i_beat.xb >>> i_shift);
            n_beat.zb = i_beat.zb + i_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

### rtl/coc_post.sv
`default_nettype none

module coc_post (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire coc_pkg::t_beat                i_beat,
    output logic                               o_valid,
    output logic signed [coc_pkg::OW-1:0]      o_x_out,
    output logic signed [coc_pkg::OW-1:0]      o_y_out,
    output logic signed [coc_pkg::OW-1:0]      o_z_out
);
    import coc_pkg::*;

    localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (LW - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] SAT_LO = RW'(-(64'sd1 <<< (LW - 1)));

    // turn (c, s) by q quarter turns, packed as {c, s}
    function automatic logic [2*CW-1:0] quad_turn(input logic [1:0] q,
                                                  input logic signed [CW-1:0] x,
                                                  input logic signed [CW-1:0] y);
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] s;
        unique case (q)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            2'd3: begin c = y;  s = -x; end
        endcase
        return {c, s};
    endfunction

    function automatic logic signed [LW-1:0] sat(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] t;
        if (v > SAT_HI) begin
            t = SAT_HI;
        end else if (v < SAT_LO) begin
            t = SAT_LO;
        end else begin
            t = v;
        end
        return t[LW-1:0];
    endfunction

    logic [POST_LAT-1:0] r_valid;

    logic [1:0]            r1_cmd, r2_cmd, r3_cmd, r4_cmd;
    logic signed [LW-1:0]  r1_a, r2_a, r3_a, r4_a;
    logic signed [LW-1:0]  r1_len2, r2_len2, r3_len2, r4_len2;
    logic signed [LW-1:0]  r1_len3, r2_len3, r3_len3, r4_len3;
    logic signed [CW-1:0]  r1_ca, r1_sa;
    logic signed [CW-1:0]  r1_cb, r1_sb, r2_cb, r2_sb, r3_cb, r3_sb;
    logic signed [PW-1:0]  r2_pc, r2_ps;
    logic signed [RW-1:0]  r3_rc, r3_rs, r4_rc, r4_rs;
    logic signed [QW-1:0]  r4_px, r4_py;
    logic signed [OW-1:0]  r_x, r_y, r_z;

    logic [2*CW-1:0]       w_qa, w_qb;
    logic signed [PW-1:0]  w_rnd_c, w_rnd_s;
    logic signed [QW-1:0]  w_rnd_x, w_rnd_y;
    logic signed [RW-1:0]  w_x, w_y, w_z;
    logic signed [OW-1:0]  n_x, n_y, n_z;

    assign w_qa = quad_turn(i_beat.qa, i_beat.xa, i_beat.ya);
    assign w_qb = quad_turn(i_beat.qb, i_beat.xb, i_beat.yb);

    assign w_rnd_c = (r2_pc + PW'(ROUND_HALF)) >>> FRAC;
    assign w_rnd_s = (r2_ps + PW'(ROUND_HALF)) >>> FRAC;
    assign w_rnd_x = (r4_px + QW'(ROUND_HALF)) >>> FRAC;
    assign w_rnd_y = (r4_py + QW'(ROUND_HALF)) >>> FRAC;

    always_comb begin
        unique case (r4_cmd)
            CMD_CYL: begin
                w_x = r4_rc;
                w_y = r4_rs;
                w_z = RW'(r4_len3);
            end
            CMD_SPH: begin
                w_x = w_rnd_x[RW-1:0];
                w_y = w_rnd_y[RW-1:0];
                w_z = r4_rc;
            end
            default: begin
                w_x = RW'(r4_a);
                w_y = RW'(r4_len2);
                w_z = RW'(r4_len3);
            end
        endcase
        n_x = OW'(sat(w_x));
        n_y = OW'(sat(w_y));
        n_z = OW'(sat(w_z));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[POST_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // quadrant fix
        r1_cmd  <= i_beat.cmd;
        r1_a    <= i_beat.a;
        r1_len2 <= i_beat.len2;
        r1_len3 <= i_beat.len3;
        r1_ca   <= w_qa[2*CW-1:CW];
        r1_sa   <= w_qa[CW-1:0];
        r1_cb   <= w_qb[2*CW-1:CW];
        r1_sb   <= w_qb[CW-1:0];
        // length times first angle
        r2_cmd  <= r1_cmd;
        r2_a    <= r1_a;
        r2_len2 <= r1_len2;
        r2_len3 <= r1_len3;
        r2_cb   <= r1_cb;
        r2_sb   <= r1_sb;
        r2_pc   <= r1_a * r1_ca;
        r2_ps   <= r1_a * r1_sa;
        // round to Q15.16
        r3_cmd  <= r2_cmd;
        r3_a    <= r2_a;
        r3_len2 <= r2_len2;
        r3_len3 <= r2_len3;
        r3_cb   <= r2_cb;
        r3_sb   <= r2_sb;
        r3_rc   <= w_rnd_c[RW-1:0];
        r3_rs   <= w_rnd_s[RW-1:0];
        // r*sin(theta) times second angle
        r4_cmd  <= r3_cmd;
        r4_a    <= r3_a;
        r4_len2 <= r3_len2;
        r4_len3 <= r3_len3;
        r4_rc   <= r3_rc;
        r4_rs   <= r3_rs;
        r4_px   <= r3_rs * r3_cb;
        r4_py   <= r3_rs * r3_sb;
        // select and saturate
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
    end

    assign o_valid = r_valid[POST_LAT-1];
    assign o_x_out = r_x;
    assign o_y_out = r_y;
    assign o_z_out = r_z;

    a_pass_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_beat.cmd != CMD_CYL) && (i_beat.cmd != CMD_SPH))
        |-> ##POST_LAT (o_x_out == $past(OW'(i_beat.a), POST_LAT)))
        else $error("pass-through x does not match its length");

    a_pass_cart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_beat.cmd == CMD_CART))
        |-> ##POST_LAT (o_y_out == $past(OW'(i_beat.len2), POST_LAT)))
        else $error("cartesian y does not match its length");

    a_pass_cyl_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_beat.cmd == CMD_CYL))
        |-> ##POST_LAT (o_z_out == $past(OW'(i_beat.len3), POST_LAT)))
        else $error("cylindrical z does not match its length");

endmodule

`default_nettype wire

### rtl/coordinate_to_cartesian.sv
// Pipeline: the accepted beat and its result strobe pass through the input register,
//   one CORDIC cell per iteration and five multiply/round stages before the result
//   is on the ports.
// Throughput: one triple per cycle; busy is low whenever reset is released.
// The receiver cannot stall: every result is on the ports for exactly one cycle.
// Reset: synchronous, active low; clears all beats in flight, busy is high during it.
`default_nettype none

module coordinate_to_cartesian (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_cmd,
    input  wire logic signed [coc_pkg::OW-1:0] i_first_coord,
    input  wire logic signed [coc_pkg::OW-1:0] i_second_coord,
    input  wire logic signed [coc_pkg::OW-1:0] i_third_coord,
    output logic                             o_valid,
    output logic signed [coc_pkg::OW-1:0]    o_x_out,
    output logic signed [coc_pkg::OW-1:0]    o_y_out,
    output logic signed [coc_pkg::OW-1:0]    o_z_out
);
    import coc_pkg::*;

    localparam logic [ANGLE_BITS-1:0] EIGHTH = ANGLE_BITS'(1) << (ANGLE_BITS - 3);

    logic                  w_take;
    logic [ANGLE_BITS-1:0] w_ta, w_tb;
    t_beat                 n_beat0;
    t_beat                 r_beat0;
    logic                  r_valid0;

    t_beat                 w_beat  [CORDIC_ITERATIONS+1];
    logic                  w_valid [CORDIC_ITERATIONS+1];

    assign busy   = !i_rst_n;
    assign w_take = start && !busy;

    // rotate by an eighth turn so the residual sits in [-1/8, 1/8)
    assign w_ta = i_second_coord[ANGLE_BITS-1:0] + EIGHTH;
    assign w_tb = i_third_coord[ANGLE_BITS-1:0] + EIGHTH;

    always_comb begin
        n_beat0.cmd  = i_cmd;
        n_beat0.a    = i_first_coord[LW-1:0];
        n_beat0.len2 = i_second_coord[LW-1:0];
        n_beat0.len3 = i_third_coord[LW-1:0];
        n_beat0.qa   = w_ta[ANGLE_BITS-1:ANGLE_BITS-2];
        n_beat0.qb   = w_tb[ANGLE_BITS-1:ANGLE_BITS-2];
        n_beat0.xa   = CW'(GAIN_Q30);
        n_beat0.ya   = '0;
        n_beat0.za   = ZW'(signed'({~w_ta[ANGLE_BITS-3], w_ta[ANGLE_BITS-4:0]}))
                       <<< (TURN_W - ANGLE_BITS);
        n_beat0.xb   = CW'(GAIN_Q30);
        n_beat0.yb   = '0;
        n_beat0.zb   = ZW'(signed'({~w_tb[ANGLE_BITS-3], w_tb[ANGLE_BITS-4:0]}))
                       <<< (TURN_W - ANGLE_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else begin
            r_valid0 <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat0 <= n_beat0;
    end

    assign w_beat[0]  = r_beat0;
    assign w_valid[0] = r_valid0;

    for (genvar k = 0; k < CORDIC_ITERATIONS; k++) begin : g_cell
        coc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (SHW'(k)),
            .i_atan  (ATAN_TURN32[k]),
            .i_valid (w_valid[k]),
            .i_beat  (w_beat[k]),
            .o_valid (w_valid[k+1]),
            .o_beat  (w_beat[k+1])
        );
    end

    coc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[CORDIC_ITERATIONS]),
        .i_beat  (w_beat[CORDIC_ITERATIONS]),
        .o_valid (o_valid),
        .o_x_out (o_x_out),
        .o_y_out (o_y_out),
        .o_z_out (o_z_out)
    );

    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> ##LATENCY o_valid)
        else $error("accepted beat did not produce a result");

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_take, LATENCY))
        else $error("result strobe without an accepted beat");

endmodule

`default_nettype wire

### verif/tb_coordinate_to_cartesian.sv
`default_nettype none

module tb_coordinate_to_cartesian;
    timeunit 1ns;
    timeprecision 1ps;

    import coc_pkg::*;

    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam int         PHASE_ITEMS = 232;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } cart_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] c1;
        logic [31:0] c2;
        logic [31:0] c3;
        bit          typed;
        cart_t       want;
    } stim_row_t;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              start          = 1'b0;
    logic [1:0]        i_cmd          = CMD_CART;
    logic signed [31:0] i_first_coord  = '0;
    logic signed [31:0] i_second_coord = '0;
    logic signed [31:0] i_third_coord  = '0;
    logic              busy;
    logic              o_valid;
    logic signed [31:0] o_x_out;
    logic signed [31:0] o_y_out;
    logic signed [31:0] o_z_out;

    cart_t pending_cart[$];
    int    n_sent    = 0;
    int    n_checked = 0;
    int    n_errors  = 0;
    int    cmd_hits[4] = '{0, 0, 0, 0};

    // lengths in Q15.16, angles in 1/65536 turn
    stim_row_t stim_rows[22] = '{
        '{CMD_CART,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000}},
        '{CMD_CART,  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
          '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}},
        '{CMD_CART,  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
          '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}},
        '{CMD_SPARE, 32'h1234_5678, 32'hDEAD_BEEF, 32'h0001_0000, 1'b1,
          '{32'h1234_5678, 32'hDEAD_BEEF, 32'h0001_0000}},
        '{CMD_CYL,   32'h0000_0000, 32'h0000_1234, 32'h55AA_55AA, 1'b1,
          '{32'h0000_0000, 32'h0000_0000, 32'h55AA_55AA}},
        '{CMD_SPH,   32'h0000_0000, 32'h0000_4000, 32'h0000_8000, 1'b1,
          '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000}},
        '{CMD_CYL,   32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{CMD_CYL,   32'h0001_0000, 32'h0000_4000, 32'h0000_0000, 1'b0, '0},
        '{CMD_CYL,   32'h0001_0000, 32'h0000_8000, 32'h0000_0000, 1'b0, '0},
        '{CMD_CYL,   32'h0001_0000, 32'h0000_C000, 32'h0000_0000, 1'b0, '0},
        '{CMD_CYL,   32'h0001_0000, 32'h0000_FFFF, 32'h0000_0000, 1'b0, '0},
        '{CMD_CYL,   32'h0001_0000, 32'h0000_2000, 32'h0000_0000, 1'b0, '0},
        '{CMD_CYL,   32'h0001_0000, 32'hFFFF_1FFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_CYL,   32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 1'b0, '0},
        '{CMD_CYL,   32'h8000_0000, 32'h0000_8000, 32'h7FFF_FFFF, 1'b0, '0},
        '{CMD_SPH,   32'h0001_0000, 32'h0000_4000, 32'h0000_0000, 1'b0, '0},
        '{CMD_SPH,   32'h7FFF_FFFF, 32'h0000_4000, 32'h0000_0000, 1'b0, '0},
        '{CMD_SPH,   32'h8000_0000, 32'h0000_4000, 32'h0000_8000, 1'b0, '0},
        '{CMD_SPH,   32'h8000_0000, 32'h0000_0000, 32'h0000_1234, 1'b0, '0},
        '{CMD_SPH,   32'hFFFF_0000, 32'hABCD_6000, 32'hFFFF_E000, 1'b0, '0},
        '{CMD_SPH,   32'h0001_0000, 32'h0000_FFFF, 32'h0000_FFFF, 1'b0, '0},
        '{CMD_CYL,   32'hFFFF_FFFF, 32'h0000_6000, 32'h0000_0001, 1'b0, '0}
    };

    coordinate_to_cartesian u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_first_coord  (i_first_coord),
        .i_second_coord (i_second_coord),
        .i_third_coord  (i_third_coord),
        .o_valid        (o_valid),
        .o_x_out        (o_x_out),
        .o_y_out        (o_y_out),
        .o_z_out        (o_z_out)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint field_length(input logic [31:0] f);
        longint v;
        v = $signed(f[LW-1:0]);
        return v;
    endfunction

    function automatic logic [31:0] clamp_length(input longint v);
        longint hi;
        longint lo;
        longint r;
        hi = (64'sd1 <<< (LW - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        r  = (v > hi) ? hi : ((v < lo) ? lo : v);
        return r[31:0];
    endfunction

    // length times Q2.30 fraction, round half up to Q15.16
    function automatic longint scale_q30(input longint len, input longint frac);
        return (len * frac + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic void turn_cos_sin(input logic [31:0] field,
                                         output longint c, output longint s);
        longint mask;
        longint eighth;
        longint quarter;
        longint t;
        longint res;
        longint ang;
        longint x;
        longint y;
        longint dx;
        longint dy;
        int     q;
        mask    = (64'sd1 <<< ANGLE_BITS) - 64'sd1;
        eighth  = 64'sd1 <<< (ANGLE_BITS - 3);
        quarter = 64'sd1 <<< (ANGLE_BITS - 2);
        t       = (longint'({32'd0, field}) & mask) + eighth;
        t       = t & mask;
        q       = int'(t >>> (ANGLE_BITS - 2)) & 3;
        // residual within +-1/8 turn, in 2^-32 turn units
        res     = (t & (quarter - 64'sd1)) - eighth;
        ang     = res * (64'sd1 <<< (TURN_W - ANGLE_BITS));
        x       = GAIN_Q30;
        y       = 0;
        for (int i = 0; i < CORDIC_ITERATIONS && i < ATAN_ENTRIES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (ang >= 0) begin
                x   = x - dx;
                y   = y + dy;
                ang = ang - longint'(ATAN_TURN32[i]);
            end else begin
                x   = x + dx;
                y   = y - dy;
                ang = ang + longint'(ATAN_TURN32[i]);
            end
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic cart_t to_cartesian(input logic [1:0] cmd, input logic [31:0] c1,
                                           input logic [31:0] c2, input logic [31:0] c3);
        longint a;
        longint xr;
        longint yr;
        longint zr;
        longint ct;
        longint st;
        longint cp;
        longint sp;
        longint rs;
        cart_t  r;
        a = field_length(c1);
        case (cmd)
            CMD_CYL: begin
                turn_cos_sin(c2, ct, st);
                xr = scale_q30(a, ct);
                yr = scale_q30(a, st);
                zr = field_length(c3);
            end
            CMD_SPH: begin
                turn_cos_sin(c2, ct, st);
                turn_cos_sin(c3, cp, sp);
                // keep r*sin(theta) unsaturated for the second product
                rs = scale_q30(a, st);
                xr = scale_q30(rs, cp);
                yr = scale_q30(rs, sp);
                zr = scale_q30(a, ct);
            end
            default: begin
                xr = a;
                yr = field_length(c2);
                zr = field_length(c3);
            end
        endcase
        r.x = clamp_length(xr);
        r.y = clamp_length(yr);
        r.z = clamp_length(zr);
        return r;
    endfunction

    function automatic logic [31:0] rand_length();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: v = 32'h8000_0000 + $urandom_range(0, 3);
            2, 3: begin
                v = $urandom_range(0, 32'h00FF_FFFF);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_angle();
        logic [31:0] v;
        v = $urandom;
        // land near an octant boundary now and then
        if ($urandom_range(0, 2) == 0) begin
            v[15:0] = 16'($urandom_range(0, 7)) * 16'h2000 + 16'($urandom_range(0, 4)) - 16'd2;
        end
        return v;
    endfunction

    task automatic send_triple(input logic [1:0] cmd, input logic [31:0] c1,
                               input logic [31:0] c2, input logic [31:0] c3,
                               input cart_t want);
        start          <= 1'b1;
        i_cmd          <= cmd;
        i_first_coord  <= c1;
        i_second_coord <= c2;
        i_third_coord  <= c3;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_cart.push_back(want);
        n_sent++;
        cmd_hits[cmd]++;
    endtask

    // drop start and scramble the payload, which must be ignored
    task automatic hold_off(input int cycles);
        start          <= 1'b0;
        i_cmd          <= 2'($urandom);
        i_first_coord  <= $urandom;
        i_second_coord <= $urandom;
        i_third_coord  <= $urandom;
        repeat (cycles) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : score_results
        cart_t want;
        if (i_rst_n && o_valid) begin
            if (pending_cart.size() == 0) begin
                $error("unexpected result beat: x %0d y %0d z %0d", o_x_out, o_y_out, o_z_out);
                n_errors++;
            end else begin
                want = pending_cart.pop_front();
                n_checked++;
                if (o_x_out !== want.x) begin
                    $error("x_out: expected %0d, got %0d", $signed(want.x), o_x_out);
                    n_errors++;
                end
                if (o_y_out !== want.y) begin
                    $error("y_out: expected %0d, got %0d", $signed(want.y), o_y_out);
                    n_errors++;
                end
                if (o_z_out !== want.z) begin
                    $error("z_out: expected %0d, got %0d", $signed(want.z), o_z_out);
                    n_errors++;
                end
            end
        end
    end

    initial begin : drive_stimulus
        int          idle_pct[4];
        int          burst;
        logic [1:0]  cmd;
        logic [31:0] c1;
        logic [31:0] c2;
        logic [31:0] c3;
        int          pick;
        idle_pct = '{0, 56, 0, 31};
        burst    = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            send_triple(stim_rows[k].cmd, stim_rows[k].c1, stim_rows[k].c2, stim_rows[k].c3,
                        stim_rows[k].typed ? stim_rows[k].want :
                        to_cartesian(stim_rows[k].cmd, stim_rows[k].c1,
                                     stim_rows[k].c2, stim_rows[k].c3));
        end

        for (int p = 0; p < 4; p++) begin
            // let the pipe drain completely between phases
            hold_off(1);
            while (pending_cart.size() != 0) @(posedge i_clk);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 9);
                cmd  = (pick < 2) ? CMD_CART : (pick < 5) ? CMD_CYL :
                       (pick < 9) ? CMD_SPH : CMD_SPARE;
                c1   = rand_length();
                c2   = (cmd == CMD_CYL || cmd == CMD_SPH) ? rand_angle() : rand_length();
                c3   = (cmd == CMD_SPH) ? rand_angle() : rand_length();
                if (burst > 0) begin
                    burst--;
                end else if ($urandom_range(0, 19) == 0) begin
                    burst = $urandom_range(10, 30);
                end else if ($urandom_range(0, 99) < idle_pct[p]) begin
                    hold_off($urandom_range(1, 6));
                end
                send_triple(cmd, c1, c2, c3, to_cartesian(cmd, c1, c2, c3));
            end
        end
        start <= 1'b0;

        while (pending_cart.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (pending_cart.size() != 0) begin
            $error("%0d expected results never arrived", pending_cart.size());
            n_errors++;
        end
        $display("Converted %0d triples: %0d cartesian, %0d cylindrical, %0d spherical, %0d spare",
                 n_sent, cmd_hits[CMD_CART], cmd_hits[CMD_CYL], cmd_hits[CMD_SPH],
                 cmd_hits[CMD_SPARE]);
        $display("Compared %0d result beats across four idle patterns, %0d mismatches",
                 n_checked, n_errors);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
